FILE: design/wfra_pkg.sv
package wfra_pkg;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXT_FRAG  = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        SCAN_ALLOC,
        SCAN_OWNER,
        SCAN_HOLE
    } scan_mode_t;

    typedef struct packed {
        logic       accept;
        logic       scan_start;
        scan_mode_t mode;
        logic       commit_alloc;
        logic       commit_free;
        logic       not_found;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic own_found;
    } dp_status_t;

endpackage

FILE: design/wfra_controller.sv
module wfra_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                command,
    input  wfra_pkg::dp_status_t sts,
    output wfra_pkg::ctrl_cmd_t  cmd,
    output logic                busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC_SCAN,
        S_OWNER_SCAN,
        S_HOLE_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        cmd          = '0;
        cmd.mode     = wfra_pkg::SCAN_ALLOC;
        state_next   = state_reg;
        busy_next    = busy_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept     = 1'b1;
                    cmd.scan_start = 1'b1;
                    busy_next      = 1'b1;
                    if (command == wfra_pkg::CMD_ALLOC)
                    begin
                        cmd.mode   = wfra_pkg::SCAN_ALLOC;
                        state_next = S_ALLOC_SCAN;
                    end
                    else
                    begin
                        cmd.mode   = wfra_pkg::SCAN_OWNER;
                        state_next = S_OWNER_SCAN;
                    end
                end
            end
            S_ALLOC_SCAN:
            begin
                if (sts.scan_done)
                begin
                    cmd.commit_alloc = 1'b1;
                    busy_next        = 1'b0;
                    state_next       = S_IDLE;
                end
            end
            S_OWNER_SCAN:
            begin
                if (sts.scan_done)
                begin
                    if (sts.own_found)
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.mode       = wfra_pkg::SCAN_HOLE;
                        state_next     = S_HOLE_SCAN;
                    end
                    else
                    begin
                        cmd.not_found = 1'b1;
                        busy_next     = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_HOLE_SCAN:
            begin
                if (sts.scan_done)
                begin
                    cmd.commit_free = 1'b1;
                    busy_next       = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

FILE: design/wfra_datapath.sv
module wfra_datapath #(
    parameter int OWNER_SLOTS = 128,
    parameter int HOLE_SLOTS  = 128,
    parameter int ADDR_WIDTH  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wfra_pkg::ctrl_cmd_t  cmd,
    output wfra_pkg::dp_status_t sts,
    input  logic                 cfg_write,
    input  logic [15:0]          cfg_wdata,
    input  logic [15:0]          owner_id,
    input  logic [15:0]          request_size,
    output logic                 done,
    output logic [2:0]           status,
    output logic [15:0]          region_start,
    output logic [15:0]          region_end
);

    localparam int AW = ADDR_WIDTH;
    localparam int HW = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
    localparam int OW = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
    localparam int SL = (HOLE_SLOTS > OWNER_SLOTS) ? HOLE_SLOTS : OWNER_SLOTS;
    localparam int CW = $clog2(SL + 1);
    localparam int SW = (AW > 16) ? AW : 16;
    localparam int TW = SW + 1;
    localparam int OMW = 16 + 2 * AW;

    localparam logic [AW-1:0] ADDR_MAX   = {AW{1'b1}};
    // The reset size saturates to the largest address on narrow address spaces.
    localparam logic [AW-1:0] RESET_SIZE = (AW >= 13) ? AW'(4096) : ADDR_MAX;

    logic [2*AW-1:0] hole_mem [HOLE_SLOTS];
    logic [OMW-1:0]  own_mem  [OWNER_SLOTS];
    logic [2*AW-1:0] hole_rd_reg;
    logic [OMW-1:0]  own_rd_reg;

    logic [AW-1:0]          msize_reg;
    logic                   fresh_reg;
    logic [HOLE_SLOTS-1:0]  hv_reg;
    logic [OWNER_SLOTS-1:0] ov_reg;
    logic [15:0]            id_reg;
    logic [15:0]            size_reg;

    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          lim_reg;
    logic [CW-1:0]          pidx_reg;
    logic                   act_reg;
    logic                   pvld_reg;
    wfra_pkg::scan_mode_t   mode_reg;

    logic                   best_found_reg;
    logic [HW-1:0]          best_idx_reg;
    logic [AW-1:0]          best_start_reg;
    logic [AW-1:0]          best_limit_reg;
    logic [AW-1:0]          best_len_reg;
    logic [TW-1:0]          total_reg;
    logic                   ofree_found_reg;
    logic [OW-1:0]          ofree_idx_reg;

    logic                   own_found_reg;
    logic [OW-1:0]          own_idx_reg;
    logic [AW-1:0]          own_start_reg;
    logic [AW-1:0]          own_limit_reg;
    logic                   aft_found_reg;
    logic [HW-1:0]          aft_idx_reg;
    logic [AW-1:0]          aft_limit_reg;
    logic                   bef_found_reg;
    logic [HW-1:0]          bef_idx_reg;
    logic [AW-1:0]          bef_start_reg;
    logic                   slot_found_reg;
    logic [HW-1:0]          slot_idx_reg;

    logic                   done_reg;
    logic [2:0]             status_reg;
    logic [15:0]            rs_reg;
    logic [15:0]            re_reg;

    // Scan sequencing.
    logic          scan_done;
    logic [HW-1:0] hidx;
    logic [OW-1:0] oidx;
    logic          h_in;
    logic          o_in;
    logic          hvk;
    logic          ovk;
    logic          fresh0;
    logic [AW-1:0] hs;
    logic [AW-1:0] hl;
    logic [AW-1:0] len;
    logic          fits;
    logic          better;
    logic [15:0]   otag;
    logic [AW-1:0] ostart;
    logic [AW-1:0] olimit;

    assign scan_done = act_reg && (cnt_reg == lim_reg) && !pvld_reg;
    assign hidx      = pidx_reg[HW-1:0];
    assign oidx      = pidx_reg[OW-1:0];
    assign h_in      = pidx_reg < CW'(HOLE_SLOTS);
    assign o_in      = pidx_reg < CW'(OWNER_SLOTS);
    assign hvk       = h_in && hv_reg[hidx];
    assign ovk       = o_in && ov_reg[oidx];
    // Entry zero holds the whole space after reset or reconfiguration until rewritten.
    assign fresh0    = fresh_reg && (hidx == '0);
    assign hs        = fresh0 ? '0 : hole_rd_reg[2*AW-1:AW];
    assign hl        = fresh0 ? msize_reg : hole_rd_reg[AW-1:0];
    assign len       = hl - hs;
    assign fits      = SW'(size_reg) <= SW'(len);
    assign better    = !best_found_reg || (len > best_len_reg) ||
                       ((len == best_len_reg) && (hs < best_start_reg));
    assign otag      = own_rd_reg[OMW-1:2*AW];
    assign ostart    = own_rd_reg[2*AW-1:AW];
    assign olimit    = own_rd_reg[AW-1:0];

    assign sts.scan_done = scan_done;
    assign sts.own_found = own_found_reg;

    // Commit logic.
    logic [SW-1:0]   e_sum;
    logic [AW-1:0]   a_end;
    logic [AW-1:0]   f_start;
    logic [AW-1:0]   f_limit;
    logic            f_nonempty;
    logic            f_has_slot;
    logic [HW-1:0]   f_slot;
    logic            f_ok;
    logic [SW-1:0]   rs_wide;
    logic [SW-1:0]   re_wide;
    logic [SW-1:0]   clamp_w;
    logic            alloc_ok;

    assign e_sum      = SW'(best_start_reg) + SW'(size_reg);
    assign a_end      = e_sum[AW-1:0];
    assign alloc_ok   = ofree_found_reg && best_found_reg;
    assign rs_wide    = SW'(best_start_reg);
    assign re_wide    = SW'(a_end);
    assign f_start    = bef_found_reg ? bef_start_reg : own_start_reg;
    assign f_limit    = aft_found_reg ? aft_limit_reg : own_limit_reg;
    assign f_nonempty = f_limit > f_start;
    assign f_has_slot = aft_found_reg || bef_found_reg || slot_found_reg;
    assign f_slot     = aft_found_reg ? aft_idx_reg :
                        (bef_found_reg ? bef_idx_reg : slot_idx_reg);
    assign f_ok       = !f_nonempty || f_has_slot;
    assign clamp_w    = (SW'(cfg_wdata) > SW'(ADDR_MAX)) ? SW'(ADDR_MAX) : SW'(cfg_wdata);

    logic            hole_we;
    logic [HW-1:0]   hole_wa;
    logic [2*AW-1:0] hole_wd;
    logic            own_we;

    always_comb
    begin
        hole_we = 1'b0;
        hole_wa = best_idx_reg;
        hole_wd = {a_end, best_limit_reg};
        if (cmd.commit_alloc && alloc_ok && (a_end != best_limit_reg))
        begin
            hole_we = 1'b1;
        end
        else if (cmd.commit_free && f_ok && f_nonempty)
        begin
            hole_we = 1'b1;
            hole_wa = f_slot;
            hole_wd = {f_start, f_limit};
        end
    end

    assign own_we = cmd.commit_alloc && alloc_ok;

    always_ff @(posedge clk)
    begin
        if (hole_we)
        begin
            hole_mem[hole_wa] <= hole_wd;
        end
        hole_rd_reg <= hole_mem[cnt_reg[HW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            own_mem[ofree_idx_reg] <= {id_reg, best_start_reg, a_end};
        end
        own_rd_reg <= own_mem[cnt_reg[OW-1:0]];
    end

    // Control state: table valid bits, scan counter and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msize_reg <= RESET_SIZE;
            fresh_reg <= 1'b1;
            hv_reg    <= HOLE_SLOTS'(1);
            ov_reg    <= '0;
            act_reg   <= 1'b0;
            pvld_reg  <= 1'b0;
            cnt_reg   <= '0;
            lim_reg   <= '0;
            mode_reg  <= wfra_pkg::SCAN_ALLOC;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit_alloc || cmd.commit_free || cmd.not_found;
            if (cfg_write)
            begin
                msize_reg <= clamp_w[AW-1:0];
                fresh_reg <= 1'b1;
                hv_reg    <= HOLE_SLOTS'(clamp_w != '0);
                ov_reg    <= '0;
            end
            if (cmd.scan_start)
            begin
                act_reg  <= 1'b1;
                pvld_reg <= 1'b0;
                cnt_reg  <= '0;
                mode_reg <= cmd.mode;
                case (cmd.mode)
                    wfra_pkg::SCAN_ALLOC: lim_reg <= CW'(SL);
                    wfra_pkg::SCAN_OWNER: lim_reg <= CW'(OWNER_SLOTS);
                    wfra_pkg::SCAN_HOLE:  lim_reg <= CW'(HOLE_SLOTS);
                    default:              lim_reg <= CW'(SL);
                endcase
            end
            else if (act_reg)
            begin
                if (cnt_reg != lim_reg)
                begin
                    cnt_reg  <= cnt_reg + 1'b1;
                    pvld_reg <= 1'b1;
                end
                else
                begin
                    pvld_reg <= 1'b0;
                    if (!pvld_reg)
                    begin
                        act_reg <= 1'b0;
                    end
                end
            end
            if (cmd.commit_alloc && alloc_ok)
            begin
                ov_reg[ofree_idx_reg] <= 1'b1;
                if (a_end == best_limit_reg)
                begin
                    hv_reg[best_idx_reg] <= 1'b0;
                end
                else if (best_idx_reg == '0)
                begin
                    fresh_reg <= 1'b0;
                end
            end
            if (cmd.commit_free && f_ok)
            begin
                ov_reg[own_idx_reg] <= 1'b0;
                if (aft_found_reg)
                begin
                    hv_reg[aft_idx_reg] <= 1'b0;
                end
                if (bef_found_reg)
                begin
                    hv_reg[bef_idx_reg] <= 1'b0;
                end
                if (f_nonempty)
                begin
                    hv_reg[f_slot] <= 1'b1;
                    if (f_slot == '0)
                    begin
                        fresh_reg <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg  <= 1'b0;
            ofree_found_reg <= 1'b0;
            own_found_reg   <= 1'b0;
            aft_found_reg   <= 1'b0;
            bef_found_reg   <= 1'b0;
            slot_found_reg  <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            if (cmd.mode == wfra_pkg::SCAN_HOLE)
            begin
                aft_found_reg  <= 1'b0;
                bef_found_reg  <= 1'b0;
                slot_found_reg <= 1'b0;
            end
            else
            begin
                best_found_reg  <= 1'b0;
                ofree_found_reg <= 1'b0;
                own_found_reg   <= 1'b0;
            end
        end
        else if (pvld_reg)
        begin
            case (mode_reg)
                wfra_pkg::SCAN_ALLOC:
                begin
                    if (hvk && fits && better)
                    begin
                        best_found_reg <= 1'b1;
                    end
                    if (o_in && !ovk && !ofree_found_reg)
                    begin
                        ofree_found_reg <= 1'b1;
                    end
                end
                wfra_pkg::SCAN_OWNER:
                begin
                    if (ovk && (otag == id_reg) && !own_found_reg)
                    begin
                        own_found_reg <= 1'b1;
                    end
                end
                wfra_pkg::SCAN_HOLE:
                begin
                    if (hvk)
                    begin
                        if (!aft_found_reg && (hs == own_limit_reg))
                        begin
                            aft_found_reg <= 1'b1;
                        end
                        else if (!bef_found_reg && (hl == own_start_reg))
                        begin
                            bef_found_reg <= 1'b1;
                        end
                    end
                    if (h_in && !hv_reg[hidx] && !slot_found_reg)
                    begin
                        slot_found_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload captured during the scans.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            id_reg   <= owner_id;
            size_reg <= request_size;
        end
        if (cmd.scan_start && (cmd.mode != wfra_pkg::SCAN_HOLE))
        begin
            total_reg <= '0;
        end
        else if (pvld_reg)
        begin
            case (mode_reg)
                wfra_pkg::SCAN_ALLOC:
                begin
                    if (hvk)
                    begin
                        total_reg <= total_reg + TW'(len);
                        if (fits && better)
                        begin
                            best_idx_reg   <= hidx;
                            best_start_reg <= hs;
                            best_limit_reg <= hl;
                            best_len_reg   <= len;
                        end
                    end
                    if (o_in && !ovk && !ofree_found_reg)
                    begin
                        ofree_idx_reg <= oidx;
                    end
                end
                wfra_pkg::SCAN_OWNER:
                begin
                    if (ovk && (otag == id_reg) && !own_found_reg)
                    begin
                        own_idx_reg   <= oidx;
                        own_start_reg <= ostart;
                        own_limit_reg <= olimit;
                    end
                end
                wfra_pkg::SCAN_HOLE:
                begin
                    if (hvk)
                    begin
                        if (!aft_found_reg && (hs == own_limit_reg))
                        begin
                            aft_idx_reg   <= hidx;
                            aft_limit_reg <= hl;
                        end
                        else if (!bef_found_reg && (hl == own_start_reg))
                        begin
                            bef_idx_reg   <= hidx;
                            bef_start_reg <= hs;
                        end
                    end
                    if (h_in && !hv_reg[hidx] && !slot_found_reg)
                    begin
                        slot_idx_reg <= hidx;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (act_reg && (cnt_reg != lim_reg))
        begin
            pidx_reg <= cnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit_alloc)
        begin
            rs_reg <= '0;
            re_reg <= '0;
            if (!ofree_found_reg)
            begin
                status_reg <= wfra_pkg::ST_FULL;
            end
            else if (!best_found_reg)
            begin
                status_reg <= (total_reg >= TW'(size_reg)) ? wfra_pkg::ST_EXT_FRAG
                                                           : wfra_pkg::ST_TOO_LARGE;
            end
            else
            begin
                status_reg <= wfra_pkg::ST_OK;
                rs_reg     <= rs_wide[15:0];
                re_reg     <= re_wide[15:0];
            end
        end
        else if (cmd.commit_free)
        begin
            status_reg <= f_ok ? wfra_pkg::ST_OK : wfra_pkg::ST_FULL;
            rs_reg     <= '0;
            re_reg     <= '0;
        end
        else if (cmd.not_found)
        begin
            status_reg <= wfra_pkg::ST_NOT_FOUND;
            rs_reg     <= '0;
            re_reg     <= '0;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign region_start = rs_reg;
    assign region_end   = re_reg;

endmodule

FILE: design/worst_fit_region_allocator_top.sv
// Allocate takes one pass over the hole and owner tables together.
// Free takes an owner pass and then a hole pass (only the owner pass when the id is unknown); each
// table has a single read port, so each pass reads its table one entry at a time.
// The result strobe rises at the edge where busy falls, and the next transaction can be accepted
// in the following cycle.
// Reset or a write of the space size leaves one hole covering the space (none for a size of zero)
// and no owners, at once. The receiver cannot stall; each result is shown for exactly one cycle.
module worst_fit_region_allocator_top #(
    parameter int OWNER_SLOTS = 128,
    parameter int HOLE_SLOTS  = 128,
    parameter int ADDR_WIDTH  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [15:0] owner_id,
    input  logic [15:0] request_size,
    input  logic        cfg_write,
    input  logic [15:0] cfg_wdata,
    output logic        done,
    output logic [2:0]  status,
    output logic [15:0] region_start,
    output logic [15:0] region_end
);

    wfra_pkg::ctrl_cmd_t  cmd;
    wfra_pkg::dp_status_t sts;

    wfra_controller u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .sts     (sts),
        .cmd     (cmd),
        .busy    (busy)
    );

    wfra_datapath #(
        .OWNER_SLOTS (OWNER_SLOTS),
        .HOLE_SLOTS  (HOLE_SLOTS),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_write    (cfg_write),
        .cfg_wdata    (cfg_wdata),
        .owner_id     (owner_id),
        .request_size (request_size),
        .done         (done),
        .status       (status),
        .region_start (region_start),
        .region_end   (region_end)
    );

endmodule

FILE: bench/worst_fit_region_allocator_top_tb.sv
module worst_fit_region_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OWNERS = 128;
    localparam int HOLES  = 128;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic        cmd;
        logic [15:0] id;
        logic [15:0] size;
        logic        is_cfg;
        logic [15:0] cfg_val;
    } request_t;

    typedef struct {
        logic [2:0]  st;
        logic [15:0] rs;
        logic [15:0] re;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        command = 1'b0;
    logic [15:0] owner_id = '0;
    logic [15:0] request_size = '0;
    logic        cfg_write = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        busy, done;
    logic [2:0]  status;
    logic [15:0] region_start, region_end;

    worst_fit_region_allocator_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .owner_id(owner_id), .request_size(request_size),
        .cfg_write(cfg_write), .cfg_wdata(cfg_wdata), .done(done),
        .status(status), .region_start(region_start), .region_end(region_end)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state.
    logic        hv [HOLES];
    logic [15:0] hs [HOLES];
    logic [15:0] hl [HOLES];
    logic        ov [OWNERS];
    logic [15:0] ot [OWNERS];
    logic [15:0] os [OWNERS];
    logic [15:0] ol [OWNERS];

    request_t pending[$];
    outcome_t expected_outcomes[$];
    int  errors = 0;
    int  results_seen = 0;
    int  sender_idle_pct = 0;
    longint cycles = 0;
    int  live_ids[$];

    task automatic reset_tables(input logic [15:0] sz);
        for (int k = 0; k < HOLES; k++)
        begin
            hv[k] = 1'b0; hs[k] = '0; hl[k] = '0;
        end
        for (int k = 0; k < OWNERS; k++)
            ov[k] = 1'b0;
        if (sz != 0)
        begin
            hv[0] = 1'b1; hl[0] = sz;
        end
    endtask

    function automatic outcome_t predict_alloc(input logic [15:0] id, input logic [15:0] size);
        outcome_t r;
        int o, best;
        int unsigned best_len, len, total;
        r = '{wfra_pkg::ST_OK, 16'd0, 16'd0};
        o = -1; best = -1; best_len = 0; total = 0;
        for (int k = 0; k < OWNERS; k++)
            if (!ov[k] && o < 0) o = k;
        if (o < 0)
        begin
            r.st = wfra_pkg::ST_FULL;
            return r;
        end
        for (int k = 0; k < HOLES; k++)
        begin
            if (hv[k] && hl[k] >= hs[k])
            begin
                len = hl[k] - hs[k];
                total += len;
                if (size <= len && (best < 0 || len > best_len ||
                    (len == best_len && hs[k] < hs[best])))
                begin
                    best = k; best_len = len;
                end
            end
        end
        if (best < 0)
        begin
            r.st = (total >= size) ? wfra_pkg::ST_EXT_FRAG : wfra_pkg::ST_TOO_LARGE;
            return r;
        end
        r.rs = hs[best];
        r.re = hs[best] + size;
        ov[o] = 1'b1; ot[o] = id; os[o] = r.rs; ol[o] = r.re;
        if (r.re == hl[best]) hv[best] = 1'b0;
        else hs[best] = r.re;
        return r;
    endfunction

    function automatic outcome_t predict_free(input logic [15:0] id);
        outcome_t r;
        int o, aft, bef, slot;
        logic [15:0] s, l;
        r = '{wfra_pkg::ST_OK, 16'd0, 16'd0};
        o = -1; aft = -1; bef = -1; slot = -1;
        for (int k = 0; k < OWNERS; k++)
            if (o < 0 && ov[k] && ot[k] == id) o = k;
        if (o < 0)
        begin
            r.st = wfra_pkg::ST_NOT_FOUND;
            return r;
        end
        s = os[o]; l = ol[o];
        for (int k = 0; k < HOLES; k++)
        begin
            if (hv[k])
            begin
                if (aft < 0 && hs[k] == ol[o]) aft = k;
                else if (bef < 0 && hl[k] == os[o]) bef = k;
            end
        end
        if (aft >= 0) l = hl[aft];
        if (bef >= 0) s = hs[bef];
        if (l > s)
        begin
            if (aft >= 0) slot = aft;
            else if (bef >= 0) slot = bef;
            else
            begin
                for (int k = 0; k < HOLES; k++)
                    if (slot < 0 && !hv[k]) slot = k;
                if (slot < 0)
                begin
                    r.st = wfra_pkg::ST_FULL;
                    return r;
                end
            end
        end
        if (aft >= 0) hv[aft] = 1'b0;
        if (bef >= 0) hv[bef] = 1'b0;
        ov[o] = 1'b0;
        if (slot >= 0)
        begin
            hv[slot] = 1'b1; hs[slot] = s; hl[slot] = l;
        end
        return r;
    endfunction

    // Driver: one transaction at a time; configuration writes only when idle.
    // A start seen high here was accepted at the rising edge just before.
    always @(negedge clk)
    begin
        request_t q;
        cycles <= cycles + 1;
        cfg_write <= 1'b0;
        start <= 1'b0;
        if (rst_n && !start && !busy && pending.size() > 0)
        begin
            q = pending[0];
            if (q.is_cfg)
            begin
                if (expected_outcomes.size() == 0 && !done)
                begin
                    void'(pending.pop_front());
                    cfg_write <= 1'b1;
                    cfg_wdata <= q.cfg_val;
                    reset_tables(q.cfg_val);
                end
            end
            else if ($urandom_range(99) >= sender_idle_pct)
            begin
                start <= 1'b1;
                command <= q.cmd;
                owner_id <= q.id;
                request_size <= q.size;
            end
        end
    end

    // Accept on the rising edge, predict right away.
    always @(posedge clk)
    begin
        request_t q;
        outcome_t e;
        if (start && !busy && rst_n)
        begin
            q = pending.pop_front();
            e = (q.cmd == wfra_pkg::CMD_ALLOC) ? predict_alloc(q.id, q.size)
                                               : predict_free(q.id);
            expected_outcomes.insert(expected_outcomes.size(), e);
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_outcomes.size() == 0)
            begin
                $error("result with no transaction waiting: status %0d", status);
                errors++;
            end
            else
            begin
                e = expected_outcomes.pop_front();
                if (status !== e.st)
                begin
                    $error("status expected %0d actual %0d", e.st, status);
                    errors++;
                end
                if (region_start !== e.rs)
                begin
                    $error("region_start expected %0d actual %0d", e.rs, region_start);
                    errors++;
                end
                if (region_end !== e.re)
                begin
                    $error("region_end expected %0d actual %0d", e.re, region_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_req(input logic c, input logic [15:0] id, input logic [15:0] sz);
        request_t r;
        r = '{c, id, sz, 1'b0, 16'd0};
        pending.insert(pending.size(), r);
    endtask

    task automatic push_cfg(input logic [15:0] v);
        request_t r;
        r = '{1'b0, 16'd0, 16'd0, 1'b1, v};
        pending.insert(pending.size(), r);
    endtask

    task automatic drain;
        while (pending.size() > 0 || expected_outcomes.size() > 0 || start)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic random_phase(input int n, input int idle, input logic [15:0] sz_max);
        int id, pick;
        sender_idle_pct = idle;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55 || live_ids.size() == 0)
            begin
                id = $urandom_range(40);
                if ($urandom_range(15) == 0) id = int'($urandom_range(65535));
                push_req(wfra_pkg::CMD_ALLOC, 16'(id),
                    ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(sz_max)));
                live_ids.insert(live_ids.size(), id);
            end
            else if (pick < 92)
            begin
                id = $urandom_range(live_ids.size() - 1);
                push_req(wfra_pkg::CMD_FREE, 16'(live_ids[id]), 16'($urandom));
                live_ids.delete(id);
            end
            else
                push_req(wfra_pkg::CMD_FREE, 16'($urandom), 16'($urandom));
        end
        drain();
    endtask

    initial
    begin
        reset_tables(16'd4096);
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed: extremes, zero size, exact fit, unknown id, merges both ways.
        push_req(wfra_pkg::CMD_ALLOC, 16'd1, 16'd0);
        push_req(wfra_pkg::CMD_ALLOC, 16'hFFFF, 16'd4096);
        push_req(wfra_pkg::CMD_ALLOC, 16'd2, 16'hFFFF);
        push_req(wfra_pkg::CMD_ALLOC, 16'd2, 16'd1);
        push_req(wfra_pkg::CMD_FREE, 16'hFFFF, 16'd0);
        push_req(wfra_pkg::CMD_FREE, 16'h1234, 16'hFFFF);
        push_req(wfra_pkg::CMD_ALLOC, 16'd3, 16'd100);
        push_req(wfra_pkg::CMD_ALLOC, 16'd4, 16'd100);
        push_req(wfra_pkg::CMD_ALLOC, 16'd5, 16'd100);
        push_req(wfra_pkg::CMD_FREE, 16'd3, 16'd0);
        push_req(wfra_pkg::CMD_FREE, 16'd5, 16'd0);
        push_req(wfra_pkg::CMD_ALLOC, 16'd6, 16'd4000);
        push_req(wfra_pkg::CMD_FREE, 16'd4, 16'd0);
        push_req(wfra_pkg::CMD_FREE, 16'd1, 16'd0);
        push_req(wfra_pkg::CMD_FREE, 16'd2, 16'd0);
        push_req(wfra_pkg::CMD_FREE, 16'd6, 16'd0);
        push_cfg(16'd0);
        push_req(wfra_pkg::CMD_ALLOC, 16'd7, 16'd0);
        push_req(wfra_pkg::CMD_ALLOC, 16'd7, 16'd1);
        push_cfg(16'hFFFF);
        push_req(wfra_pkg::CMD_ALLOC, 16'd8, 16'hFFFF);
        push_req(wfra_pkg::CMD_FREE, 16'd8, 16'd0);
        drain();

        // Fill the owner table with two-unit regions, then free every other one to
        // fragment the hole table.
        push_cfg(16'd300);
        for (int i = 0; i < 130; i++) push_req(wfra_pkg::CMD_ALLOC, 16'(i), 16'd2);
        for (int i = 0; i < 128; i += 2) push_req(wfra_pkg::CMD_FREE, 16'(i), 16'd0);
        push_req(wfra_pkg::CMD_ALLOC, 16'd900, 16'd3);
        drain();

        push_cfg(16'd1);
        live_ids.delete();
        random_phase(120, 0, 2);
        push_cfg(16'd4096);
        live_ids.delete();
        random_phase(300, 0, 200);
        push_cfg(16'd600);
        live_ids.delete();
        random_phase(300, 63, 30);
        push_cfg(16'hFFFF);
        live_ids.delete();
        random_phase(250, 38, 3000);
        push_cfg(16'd64);
        live_ids.delete();
        random_phase(150, 10, 8);

        $display("Covered %0d results across several memory sizes and idle mixes,",
            results_seen);
        $display("including full tables, fragmentation and coalescing frees.");
        if (errors == 0 && expected_outcomes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
